@@ rtl/core/sierpinski_carpet_pixel_unit_assert.svh @@
// assertion macros for the sierpinski carpet pixel unit
// expects clk and rst_n in the scope of use
`ifndef SIERPINSKI_CARPET_PIXEL_UNIT_ASSERT_SVH
`define SIERPINSKI_CARPET_PIXEL_UNIT_ASSERT_SVH

// same-cycle implication
`define SCP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/scp_pkg.sv @@
// shared types, constants and the divide-by-three helper for the carpet unit
// no dependencies
`timescale 1ns / 1ps

package scp_pkg;

  localparam int PIX_W = 12;
  localparam int CFG_W = 3;
  localparam int GRAY_W = 8;

  localparam logic [CFG_W-1:0] SIZE_EXP_RST = 3'd7;
  localparam logic [CFG_W-1:0] LEVEL_RST = 3'd0;

  localparam logic [GRAY_W-1:0] GRAY_IN_SET = 8'd0;
  localparam logic [GRAY_W-1:0] GRAY_REMOVED = 8'd255;

  // floor(2^PIX_W / 3), underestimates v/3 by less than one
  localparam logic [2*PIX_W-1:0] RECIP3 = (2*PIX_W)'((2**PIX_W) / 3);

  typedef enum logic [0:0] {
    REG_SIZE_EXP = 1'b0,
    REG_LEVEL    = 1'b1
  } scp_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] qx;
    logic [PIX_W-1:0] qy;
    logic             hit;
  } scp_stage_t;

  typedef struct packed {
    logic [PIX_W-1:0] q;
    logic [1:0]       r;
  } scp_div3_t;

  function automatic scp_div3_t scp_div3(input logic [PIX_W-1:0] v);
    logic [2*PIX_W-1:0] prod;
    logic [PIX_W-1:0]   q0;
    logic [PIX_W+1:0]   three_q;
    logic [PIX_W+1:0]   r0;
    scp_div3_t          res;
    prod    = {{PIX_W{1'b0}}, v} * RECIP3;
    q0      = prod[2*PIX_W-1:PIX_W];
    three_q = {2'b00, q0} + {1'b0, q0, 1'b0};
    r0      = {2'b00, v} - three_q;
    if (r0 >= (PIX_W+2)'(3)) begin
      res.q = q0 + PIX_W'(1);
      res.r = 2'(r0 - (PIX_W+2)'(3));
    end else begin
      res.q = q0;
      res.r = r0[1:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/core/scp_in_if.sv @@
// input channel: pixel coordinate pair with valid/ready
// depends on scp_pkg
`timescale 1ns / 1ps

interface scp_in_if;
  logic                    valid;
  logic                    ready;
  logic [scp_pkg::PIX_W-1:0] pixel_x;
  logic [scp_pkg::PIX_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

@@ rtl/core/scp_out_if.sv @@
// result channel: carpet membership and gray level with valid/ready
// depends on scp_pkg
`timescale 1ns / 1ps

interface scp_out_if;
  logic                     valid;
  logic                     ready;
  logic                     in_set;
  logic [scp_pkg::GRAY_W-1:0] gray;

  modport source (output valid, output in_set, output gray, input ready);
  modport sink (input valid, input in_set, input gray, output ready);
endinterface

@@ rtl/core/scp_cell.sv @@
// one digit cell: peels one base-3 digit off each coordinate and registers the rest
// depends on scp_pkg
`timescale 1ns / 1ps

module scp_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                digit_en,
  input  logic                up_valid,
  output logic                up_ready,
  input  scp_pkg::scp_stage_t up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output scp_pkg::scp_stage_t dn_data
);
  import scp_pkg::*;

  logic       valid_r;
  scp_stage_t data_r;
  scp_stage_t data_nxt;
  scp_div3_t  dx;
  scp_div3_t  dy;

  always_comb begin
    dx = scp_div3(up_data.qx);
    dy = scp_div3(up_data.qy);
    data_nxt.qx  = dx.q;
    data_nxt.qy  = dy.q;
    data_nxt.hit = up_data.hit | (digit_en && (dx.r == 2'd1) && (dy.r == 2'd1));
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

@@ rtl/core/sierpinski_carpet_pixel_unit.sv @@
// channel  | dir | transaction payload
// in_chan  | in  | pixel_x[11:0], pixel_y[11:0]
// out_chan | out | in_set, gray[7:0]
// cfg_*    | in  | cfg_index selects size_exponent or level, cfg_wdata[2:0]
//
// one transaction per clock unless out_chan.ready holds the chain back; one cell per base-3 digit
// each cell holds its own register stage, so bubbles collapse under stalls
// in_chan.ready falls only when every cell holds a pending result
// synchronous active-low reset empties the chain and loads the default config
// depends on scp_pkg, scp_in_if, scp_out_if, scp_cell and the assertion header
`timescale 1ns / 1ps
`include "sierpinski_carpet_pixel_unit_assert.svh"

module sierpinski_carpet_pixel_unit #(
  parameter int MAX_DIGITS = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  scp_in_if.sink                       in_chan,
  scp_out_if.source                    out_chan,
  input  logic                         cfg_we,
  input  scp_pkg::scp_reg_e            cfg_index,
  input  logic [scp_pkg::CFG_W-1:0]    cfg_wdata
);
  import scp_pkg::*;

  localparam int DW = $clog2(MAX_DIGITS + 1);
  localparam int KW = (DW > CFG_W) ? DW : CFG_W;

  logic [CFG_W-1:0]      size_exp_r;
  logic [CFG_W-1:0]      level_r;
  logic [KW-1:0]         e_eff;
  logic [KW-1:0]         l_eff;
  logic [KW-1:0]         lo_digit;
  logic [MAX_DIGITS-1:0] digit_mask;

  logic [MAX_DIGITS:0]   vld;
  logic [MAX_DIGITS:0]   rdy;
  scp_stage_t            chain [MAX_DIGITS+1];

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_exp_r <= SIZE_EXP_RST;
      level_r    <= LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIZE_EXP: size_exp_r <= cfg_wdata;
        REG_LEVEL:    level_r    <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // window of examined digit positions
  always_comb begin
    e_eff    = (KW'(size_exp_r) > KW'(MAX_DIGITS)) ? KW'(MAX_DIGITS) : KW'(size_exp_r);
    l_eff    = (KW'(level_r) > e_eff) ? e_eff : KW'(level_r);
    lo_digit = e_eff - l_eff;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      digit_mask[k] = (KW'(k) >= lo_digit) && (KW'(k) < e_eff);
    end
  end

  assign vld[0]       = in_chan.valid;
  assign in_chan.ready = rdy[0];
  assign chain[0].qx  = in_chan.pixel_x;
  assign chain[0].qy  = in_chan.pixel_y;
  assign chain[0].hit = 1'b0;

  for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
    scp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .digit_en (digit_mask[k]),
      .up_valid (vld[k]),
      .up_ready (rdy[k]),
      .up_data  (chain[k]),
      .dn_valid (vld[k+1]),
      .dn_ready (rdy[k+1]),
      .dn_data  (chain[k+1])
    );
  end

  assign rdy[MAX_DIGITS] = out_chan.ready;
  assign out_chan.valid  = vld[MAX_DIGITS];
  assign out_chan.in_set = !chain[MAX_DIGITS].hit;
  assign out_chan.gray   = chain[MAX_DIGITS].hit ? GRAY_REMOVED : GRAY_IN_SET;

  `SCP_ASSERT_SAME(a_full_when_blocked, !in_chan.ready, &vld[MAX_DIGITS:1], "input blocked with a free cell")
  `SCP_ASSERT_NEXT(a_accept_fills_first, in_chan.valid && in_chan.ready, vld[1], "accepted transaction lost at first cell")
  `SCP_ASSERT_SAME(a_level_zero_no_digits, l_eff == '0, digit_mask == '0, "digit enabled at level zero")

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// self-checking bench for sierpinski_carpet_pixel_unit: directed table, then random phases
// depends on scp_pkg, scp_in_if, scp_out_if and the unit itself

module testbench;
  import scp_pkg::*;

  localparam int NUM_CASES = 20;
  localparam int NUM_PHASES = 12;
  localparam int PHASE_PIXELS = 150;
  localparam int DIGITS = 7;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {CHK_MODEL, CHK_KEEP, CHK_DROP} pixel_check_e;

  typedef struct packed {
    logic [CFG_W-1:0] exp;
    logic [CFG_W-1:0] lvl;
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    pixel_check_e     chk;
  } pixel_case_t;

  typedef struct packed {
    logic              in_set;
    logic [GRAY_W-1:0] gray;
  } shade_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  scp_reg_e cfg_index = REG_SIZE_EXP;
  logic [CFG_W-1:0] cfg_wdata = '0;

  scp_in_if in_chan();
  scp_out_if out_chan();

  sierpinski_carpet_pixel_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  logic [CFG_W-1:0] size_exp_q = SIZE_EXP_RST;
  logic [CFG_W-1:0] level_q = LEVEL_RST;
  shade_t pending_shades[$];
  shade_t shade_on_offer = '0;
  int mismatches = 0;
  int pixels_sent = 0;
  int removed_seen = 0;
  int kept_seen = 0;
  int settings_run = 0;
  int cycle_count = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int rx_hold = 0;
  int rx_stall = 0;

  pixel_case_t pixel_cases [NUM_CASES] = '{
    '{3'd7, 3'd0, 12'd0,    12'd0,    CHK_KEEP},
    '{3'd7, 3'd0, 12'd4095, 12'd4095, CHK_KEEP},
    '{3'd7, 3'd7, 12'd1,    12'd1,    CHK_DROP},
    '{3'd7, 3'd7, 12'd0,    12'd0,    CHK_KEEP},
    '{3'd7, 3'd7, 12'd2186, 12'd2186, CHK_KEEP},
    '{3'd7, 3'd7, 12'd1093, 12'd1093, CHK_DROP},
    '{3'd7, 3'd7, 12'd4095, 12'd0,    CHK_MODEL},
    '{3'd7, 3'd1, 12'd729,  12'd729,  CHK_DROP},
    '{3'd7, 3'd1, 12'd728,  12'd1458, CHK_KEEP},
    '{3'd0, 3'd0, 12'd4095, 12'd0,    CHK_KEEP},
    '{3'd0, 3'd5, 12'd1,    12'd1,    CHK_KEEP},
    '{3'd2, 3'd5, 12'd4,    12'd4,    CHK_DROP},
    '{3'd2, 3'd5, 12'd3,    12'd3,    CHK_DROP},
    '{3'd2, 3'd5, 12'd2,    12'd2,    CHK_KEEP},
    '{3'd1, 3'd1, 12'd1,    12'd1,    CHK_DROP},
    '{3'd1, 3'd1, 12'd1,    12'd0,    CHK_KEEP},
    '{3'd2, 3'd2, 12'd10,   12'd10,   CHK_DROP},
    '{3'd2, 3'd2, 12'd9,    12'd9,    CHK_KEEP},
    '{3'd3, 3'd1, 12'd4095, 12'd4095, CHK_KEEP},
    '{3'd5, 3'd3, 12'd100,  12'd200,  CHK_MODEL}
  };

  always #4 clk = ~clk;

  function automatic int unsigned pow3(input int unsigned e);
    int unsigned r;
    r = 1;
    repeat (e) r = r * 3;
    return r;
  endfunction

  // carpet membership of one pixel under the current register copy
  function automatic shade_t carpet_shade(input logic [PIX_W-1:0] px,
                                          input logic [PIX_W-1:0] py);
    int unsigned e;
    int unsigned l;
    int unsigned blk;
    int unsigned bx;
    int unsigned by;
    shade_t r;
    e = 32'(size_exp_q);
    if (e > DIGITS) e = DIGITS;
    l = 32'(level_q);
    if (l > e) l = e;
    blk = pow3(e - l);
    bx = 32'(px) / blk;
    by = 32'(py) / blk;
    r.in_set = 1'b1;
    for (int i = 0; i < l; i++) begin
      if (bx % 3 == 1 && by % 3 == 1) r.in_set = 1'b0;
      bx = bx / 3;
      by = by / 3;
    end
    r.gray = r.in_set ? GRAY_IN_SET : GRAY_REMOVED;
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] pick_coord(input int unsigned side);
    if ($urandom_range(0, 7) == 0) return PIX_W'($urandom_range(0, 4095));
    return PIX_W'($urandom_range(0, side - 1));
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("result %0d: %s got %0d, expected %0d",
             removed_seen + kept_seen, field, got, want);
    mismatches++;
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py,
                            input shade_t want);
    int gap;
    gap = (tx_idle_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_chan.valid = 1'b0;
    end
    @(negedge clk);
    in_chan.valid = 1'b1;
    in_chan.pixel_x = px;
    in_chan.pixel_y = py;
    shade_on_offer = want;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic drain;
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (pending_shades.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input scp_reg_e idx, input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_SIZE_EXP) size_exp_q = v;
    else level_q = v;
  endtask

  task automatic apply_setting(input logic [CFG_W-1:0] e, input logic [CFG_W-1:0] l);
    drain();
    if (e != size_exp_q) write_reg(REG_SIZE_EXP, e);
    if (l != level_q) write_reg(REG_LEVEL, l);
    settings_run++;
  endtask

  // receiver: random stall bursts plus an optional long hold-off
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_chan.ready = 1'b0;
      rx_hold--;
    end else if (rx_stall > 0) begin
      out_chan.ready = 1'b0;
      rx_stall--;
    end else begin
      out_chan.ready = 1'b1;
      if (rx_idle_en && $urandom_range(0, 7) == 0) rx_stall = $urandom_range(1, 15);
    end
  end

  // result check first, then record the transaction accepted on the input
  always @(posedge clk) begin
    shade_t want;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        if (out_chan.in_set) kept_seen++;
        else removed_seen++;
        if (pending_shades.size() == 0) begin
          report_mismatch("unexpected result, in_set", 32'(out_chan.in_set), -1);
        end else begin
          want = pending_shades.pop_front();
          if (out_chan.in_set !== want.in_set)
            report_mismatch("in_set", 32'(out_chan.in_set), 32'(want.in_set));
          if (out_chan.gray !== want.gray)
            report_mismatch("gray", 32'(out_chan.gray), 32'(want.gray));
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        pending_shades.push_back(shade_on_offer);
        pixels_sent++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_shades.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [CFG_W-1:0] e;
    logic [CFG_W-1:0] l;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    shade_t want;
    int unsigned side;
    in_chan.valid = 1'b0;
    in_chan.pixel_x = '0;
    in_chan.pixel_y = '0;
    out_chan.ready = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (pixel_cases[i]) begin
      if (pixel_cases[i].exp != size_exp_q || pixel_cases[i].lvl != level_q)
        apply_setting(pixel_cases[i].exp, pixel_cases[i].lvl);
      case (pixel_cases[i].chk)
        CHK_KEEP: want = '{1'b1, GRAY_IN_SET};
        CHK_DROP: want = '{1'b0, GRAY_REMOVED};
        default: want = carpet_shade(pixel_cases[i].x, pixel_cases[i].y);
      endcase
      send_pixel(pixel_cases[i].x, pixel_cases[i].y, want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin e = 3'd7; l = 3'd7; end
        1: begin e = 3'd0; l = 3'd0; end
        2: begin e = 3'd1; l = 3'd1; end
        3: begin e = 3'd3; l = 3'd2; end
        4: begin e = 3'd7; l = 3'd3; end
        5: begin e = 3'd2; l = 3'd7; end
        6: begin e = 3'd5; l = 3'd5; end
        7: begin e = 3'd4; l = 3'd6; end
        8: begin e = 3'd6; l = 3'd4; end
        default: begin
          e = CFG_W'($urandom_range(0, 7));
          l = CFG_W'($urandom_range(0, 7));
        end
      endcase
      apply_setting(e, l);
      tx_idle_en = (p < NUM_PHASES - 2) && (p % 4 != 3);
      rx_idle_en = tx_idle_en;
      // long receiver hold-off with the sender pushing back to back
      if (p == 4) begin
        tx_idle_en = 1'b0;
        rx_hold = 60;
      end
      side = pow3(32'(size_exp_q));
      for (int k = 0; k < PHASE_PIXELS; k++) begin
        if (k == PHASE_PIXELS / 2) begin
          drain();
          tx_idle_en = (p < NUM_PHASES - 2) && (p % 4 != 3);
        end
        px = pick_coord(side);
        py = pick_coord(side);
        send_pixel(px, py, carpet_shade(px, py));
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (pending_shades.size() != 0)
      report_mismatch("results missing", 0, pending_shades.size());
    $display("%0d pixels over %0d carpet settings, all exponents and depths 0..7",
             pixels_sent, settings_run);
    $display("%0d results in the carpet, %0d removed", kept_seen, removed_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sierpinski_carpet_pixel_unit.f @@
+incdir+rtl/core
rtl/core/scp_pkg.sv
rtl/core/scp_in_if.sv
rtl/core/scp_out_if.sv
rtl/core/scp_cell.sv
rtl/core/sierpinski_carpet_pixel_unit.sv
tb/sv/testbench.sv
